// ===== design/sinusoidal_position_encoding_add_macros.svh =====
// Assertion helpers for sinusoidal_position_encoding_add.sv, which checks its own logic.
// Both macros expect clk and rst_n in scope.
`ifndef SINUSOIDAL_POSITION_ENCODING_ADD_MACROS_SVH
`define SINUSOIDAL_POSITION_ENCODING_ADD_MACROS_SVH

// Same-cycle implication.
`define SPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/spe_pkg.sv =====
package spe_pkg;

  localparam int EMBED_DIM = 64;
  localparam int MAX_SEQ   = 2048;

  localparam int VALUE_W = 16;
  localparam int POS_W   = 11;
  localparam int DIM_W   = 6;
  localparam int PAIRS   = 32;
  localparam int PAIR_W  = 5;
  localparam int PHASE_W = 32;
  localparam int PROD_W  = POS_W + PHASE_W;
  localparam int QW_BITS = 8;
  localparam int QW_SIZE = 256;
  localparam int IDX_W   = QW_BITS + 1;
  localparam int MAG_W   = 13;
  localparam int TERM_W  = 14;
  localparam int SUM_W   = 17;

  localparam logic [63:0] LOG2_1E4_Q32 = 64'd57070290109;
  localparam logic [63:0] LN2_Q32      = 64'd2977044472;
  localparam logic [63:0] INV2PI_Q32   = 64'd683565276;
  localparam logic [63:0] HALFPI_Q30   = 64'd1686629713;

  localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 16'sh7FFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 16'sh8000;
  localparam logic signed [SUM_W-1:0]   SUM_MAX   = 17'sh07FFF;
  localparam logic signed [SUM_W-1:0]   SUM_MIN   = 17'sh18000;

  // exp(-z), z in [0,1), both Q32
  function automatic logic [63:0] exp_neg_q32(input logic [63:0] z);
    logic [63:0] term;
    logic [63:0] acc;
    term = 64'd1 << 32;
    acc  = term;
    for (int m = 1; m <= 20; m++) begin
      term = ((term * z) >> 32) / 64'(m);
      if (m[0]) acc = acc - term;
      else acc = acc + term;
    end
    return acc;
  endfunction

  // Inverse frequency of one sine/cosine pair in turns per position, Q0.32
  function automatic logic [PHASE_W-1:0] pair_freq(input int k);
    logic [63:0] t;
    logic [63:0] frac;
    logic [63:0] z;
    logic [63:0] e;
    logic [63:0] f;
    logic [63:0] shifted;
    logic [31:0] whole;
    if (2 * k >= EMBED_DIM) return '0;
    t       = (64'(2 * k) * LOG2_1E4_Q32) / 64'(EMBED_DIM);
    whole   = t[63:32];
    frac    = {32'd0, t[31:0]};
    z       = (frac * LN2_Q32) >> 32;
    e       = exp_neg_q32(z);
    f       = (e * INV2PI_Q32) >> 32;
    if (whole > 32'd31) return '0;
    shifted = f >> whole;
    return shifted[PHASE_W-1:0];
  endfunction

  // round(4096 * sin(j * pi / 512)), Q1.12
  function automatic logic [MAG_W-1:0] quarter_sine(input int j);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] r;
    x    = (64'(j) * HALFPI_Q30) / 64'(QW_SIZE);
    term = x;
    acc  = x;
    for (int m = 1; m <= 12; m++) begin
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'((2 * m) * (2 * m + 1));
      if (m[0]) acc = acc - term;
      else acc = acc + term;
    end
    r = (acc + (64'd1 << 17)) >> 18;
    return r[MAG_W-1:0];
  endfunction

  function automatic logic [PAIRS*PHASE_W-1:0] build_freq_rom();
    logic [PAIRS*PHASE_W-1:0] rom;
    rom = '0;
    for (int k = 0; k < PAIRS; k++) rom[k*PHASE_W +: PHASE_W] = pair_freq(k);
    return rom;
  endfunction

  function automatic logic [(QW_SIZE+1)*MAG_W-1:0] build_quarter_rom();
    logic [(QW_SIZE+1)*MAG_W-1:0] rom;
    rom = '0;
    for (int j = 0; j <= QW_SIZE; j++) rom[j*MAG_W +: MAG_W] = quarter_sine(j);
    return rom;
  endfunction

  localparam logic [PAIRS*PHASE_W-1:0]       FREQ_ROM    = build_freq_rom();
  localparam logic [(QW_SIZE+1)*MAG_W-1:0]   QUARTER_ROM = build_quarter_rom();

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    logic [PHASE_W-1:0]        freq;
    logic                      odd;
    logic                      active;
  } spe_lookup_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [PHASE_W-1:0]        phase;
    logic                      active;
  } spe_phase_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [TERM_W-1:0]  term;
  } spe_term_t;

endpackage

// ===== design/spe_in_if.sv =====
interface spe_in_if
  import spe_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] element_value;
  logic [POS_W-1:0]          position;
  logic [DIM_W-1:0]          dimension;

  modport source (output valid, output element_value, output position, output dimension,
                  input ready);
  modport sink   (input valid, input element_value, input position, input dimension,
                  output ready);
endinterface

// ===== design/spe_out_if.sv =====
interface spe_out_if
  import spe_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] encoded_value;
  logic                      saturated;

  modport source (output valid, output encoded_value, output saturated, input ready);
  modport sink   (input valid, input encoded_value, input saturated, output ready);
endinterface

// ===== design/sinusoidal_position_encoding_add.sv =====
// Sinusoidal position encoding adder.
// in_ch carries one embedding element (signed Q4.12) with its sequence position
// and dimension index; out_ch returns the element plus sin (even dimension) or
// cos (odd dimension) of the position phase, saturated to 16 bits with a flag.
// Both channels move a beat when valid and ready are high at a rising edge.
// The path from the accepting edge to out_ch.valid runs through four register
// stages: frequency table read (loaded at the accepting edge), 11x32 phase
// multiply, quarter-wave table read, add and clip into the output register.
// Throughput is one beat per cycle while out_ch is ready; the phase multiply
// stage is the deepest path. Both tables are constants, so the block is ready
// right after reset. Synchronous active-low reset empties every stage; payload
// registers keep whatever they held. When out_ch stalls, each stage holds its
// beat and ready passes back combinationally through the stages, so in_ch.ready
// drops only once all four stages are full. No beat is lost or repeated.
`include "sinusoidal_position_encoding_add_macros.svh"

module sinusoidal_position_encoding_add
  import spe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  spe_in_if.sink     in_ch,
  spe_out_if.source  out_ch
);

  logic        phase_valid;
  logic        phase_ready;
  spe_phase_t  phase_data;
  logic        term_valid;
  logic        term_ready;
  spe_term_t   term_data;

  spe_phase u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .src         (in_ch),
    .phase_valid (phase_valid),
    .phase_ready (phase_ready),
    .phase_data  (phase_data)
  );

  spe_wave u_wave (
    .clk         (clk),
    .rst_n       (rst_n),
    .phase_valid (phase_valid),
    .phase_ready (phase_ready),
    .phase_data  (phase_data),
    .term_valid  (term_valid),
    .term_ready  (term_ready),
    .term_data   (term_data)
  );

  spe_sat u_sat (
    .clk        (clk),
    .rst_n      (rst_n),
    .term_valid (term_valid),
    .term_ready (term_ready),
    .term_data  (term_data),
    .dst        (out_ch)
  );

  `SPE_ASSERT_NOW(a_full_only_when_stalled, !in_ch.ready, out_ch.valid && !out_ch.ready, "input stalled while output drains")
  `SPE_ASSERT_NEXT(a_term_hold, term_valid && !term_ready, term_valid && $stable(term_data), "term stage changed while stalled")
  `SPE_ASSERT_NOW(a_sat_at_limit, out_ch.valid && out_ch.saturated, out_ch.encoded_value == VALUE_MAX || out_ch.encoded_value == VALUE_MIN, "saturated beat not at a limit")

endmodule

// ===== design/spe_phase.sv =====
module spe_phase
  import spe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  spe_in_if.sink      src,
  output logic        phase_valid,
  input  logic        phase_ready,
  output spe_phase_t  phase_data
);

  logic        lookup_valid_r;
  spe_lookup_t lookup_r;
  spe_lookup_t lookup_nxt;
  logic        lookup_ready;
  logic        phase_valid_r;
  spe_phase_t  phase_r;
  spe_phase_t  phase_nxt;
  logic        phase_stage_ready;
  logic [PAIR_W-1:0] pair;
  logic [PROD_W-1:0] prod;

  assign phase_stage_ready = !phase_valid_r || phase_ready;
  assign lookup_ready      = !lookup_valid_r || phase_stage_ready;
  assign src.ready         = lookup_ready;

  // Stage 1: fetch the pair frequency
  always_comb begin
    pair                = src.dimension[DIM_W-1:1];
    lookup_nxt.value    = src.element_value;
    lookup_nxt.position = src.position;
    lookup_nxt.freq     = FREQ_ROM[pair*PHASE_W +: PHASE_W];
    lookup_nxt.odd      = src.dimension[0];
    lookup_nxt.active   = (32'(src.position) < MAX_SEQ) && (32'(src.dimension) < EMBED_DIM);
  end

  // Stage 2: phase in turns, wrapping at one turn; cosine leads by a quarter turn
  always_comb begin
    prod             = PROD_W'(lookup_r.position) * PROD_W'(lookup_r.freq);
    phase_nxt.value  = lookup_r.value;
    phase_nxt.phase  = prod[PHASE_W-1:0] + (lookup_r.odd ? QUARTER_TURN : '0);
    phase_nxt.active = lookup_r.active;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lookup_valid_r <= 1'b0;
      phase_valid_r  <= 1'b0;
    end else begin
      if (lookup_ready) lookup_valid_r <= src.valid;
      if (phase_stage_ready) phase_valid_r <= lookup_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_ready && src.valid) lookup_r <= lookup_nxt;
    if (phase_stage_ready && lookup_valid_r) phase_r <= phase_nxt;
  end

  assign phase_valid = phase_valid_r;
  assign phase_data  = phase_r;

endmodule

// ===== design/spe_wave.sv =====
module spe_wave
  import spe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        phase_valid,
  output logic        phase_ready,
  input  spe_phase_t  phase_data,
  output logic        term_valid,
  input  logic        term_ready,
  output spe_term_t   term_data
);

  logic                      term_valid_r;
  spe_term_t                 term_r;
  spe_term_t                 term_nxt;
  logic [1:0]                quadrant;
  logic [QW_BITS-1:0]        step;
  logic [IDX_W-1:0]          idx;
  logic [MAG_W-1:0]          mag;
  logic signed [TERM_W-1:0]  mag_s;

  assign phase_ready = !term_valid_r || term_ready;

  // Fold the quadrant onto the quarter-wave table
  always_comb begin
    quadrant       = phase_data.phase[PHASE_W-1 -: 2];
    step           = phase_data.phase[PHASE_W-3 -: QW_BITS];
    idx            = quadrant[0] ? IDX_W'(QW_SIZE) - {1'b0, step} : {1'b0, step};
    mag            = QUARTER_ROM[idx*MAG_W +: MAG_W];
    mag_s          = signed'({1'b0, mag});
    term_nxt.value = phase_data.value;
    if (!phase_data.active) term_nxt.term = '0;
    else if (quadrant[1]) term_nxt.term = -mag_s;
    else term_nxt.term = mag_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_valid_r <= 1'b0;
    end else if (phase_ready) begin
      term_valid_r <= phase_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (phase_ready && phase_valid) term_r <= term_nxt;
  end

  assign term_valid = term_valid_r;
  assign term_data  = term_r;

endmodule

// ===== design/spe_sat.sv =====
module spe_sat
  import spe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       term_valid,
  output logic       term_ready,
  input  spe_term_t  term_data,
  spe_out_if.source  dst
);

  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] value_nxt;
  logic                      sat_r;
  logic                      sat_nxt;
  logic signed [SUM_W-1:0]   sum;

  assign term_ready = !out_valid_r || dst.ready;

  // Clip to the 16-bit range and flag it
  always_comb begin
    sum = SUM_W'(term_data.value) + SUM_W'(term_data.term);
    if (sum > SUM_MAX) begin
      value_nxt = VALUE_MAX;
      sat_nxt   = 1'b1;
    end else if (sum < SUM_MIN) begin
      value_nxt = VALUE_MIN;
      sat_nxt   = 1'b1;
    end else begin
      value_nxt = sum[VALUE_W-1:0];
      sat_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (term_ready) begin
      out_valid_r <= term_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (term_ready && term_valid) begin
      value_r <= value_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign dst.valid         = out_valid_r;
  assign dst.encoded_value = value_r;
  assign dst.saturated     = sat_r;

endmodule
